// File: rtl/core/tga_rle_pixel_decoder_macros.svh
// Assertion macros for the TGA run-length pixel decoder.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle
`define TGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/tga_rle_pkg.sv
// Types and constants shared by the TGA run-length pixel decoder.
`default_nettype none
package tga_rle_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MIN_WIDTH  = 4;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int CNT_W      = 8;
    localparam int TOT_W      = 2 * DIM_W - 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [7:0] OPAQUE     = 8'd255;
    localparam logic [7:0] COUNT_MASK = 8'h7f;
    localparam logic [7:0] RUN_BIT    = 8'h80;

    // Configuration register indexes
    localparam logic [7:0] REG_IMAGE_WIDTH   = 8'd0;
    localparam logic [7:0] REG_IMAGE_HEIGHT  = 8'd1;
    localparam logic [7:0] REG_ALPHA_PRESENT = 8'd2;

    // Channel byte position within a pixel
    typedef enum logic [1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2,
        CH_ALPHA = 2'd3
    } chan_t;

    // One decoded pixel group: a count of equal pixels and their colour
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
    } cmd_t;

    // Effective geometry for the span splitter
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [POS_W-1:0] last_row;
    } geom_t;

endpackage
`default_nettype wire

// File: rtl/core/tga_rle_if.sv
// Channel interfaces: coded byte input, span output and configuration writes.
`default_nettype none
interface tga_rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_rle_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] buffer_row;
    logic [11:0] start_column;
    logic [7:0]  span_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_span;
    logic        image_done;

    modport source (output valid, output buffer_row, output start_column,
                    output span_length, output red, output green, output blue,
                    output alpha, output last_span, output image_done,
                    input ready);
    modport sink   (input valid, input buffer_row, input start_column,
                    input span_length, input red, input green, input blue,
                    input alpha, input last_span, input image_done,
                    output ready);
endinterface

interface tga_rle_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [12:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tga_rle_front.sv
// Front end: packet header and channel byte parsing, pixel group generation.
`default_nettype none
module tga_rle_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rewind,
    input  logic                     alpha_present,
    input  logic [tga_rle_pkg::TOT_W-1:0] total_pixels,
    tga_rle_in_if.sink               pix_in,
    output logic                     cmd_push,
    output tga_rle_pkg::cmd_t        cmd,
    input  logic                     cmd_full
);
    import tga_rle_pkg::*;

    logic             expect_reg, expect_next;
    logic             run_reg, run_next;
    logic [CNT_W-1:0] left_reg, left_next;
    chan_t            chan_reg, chan_next;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       red_reg, red_next;
    logic             fresh_reg, fresh_next;
    logic [TOT_W-1:0] remaining_reg, remaining_next;

    logic             beat;
    logic [TOT_W-1:0] rem;
    chan_t            last_ch;
    logic             final_byte;
    logic [CNT_W-1:0] pix_count;
    logic             image_end;

    assign pix_in.ready = !cmd_full && !rewind;
    assign beat         = pix_in.valid && pix_in.ready;

    // Pixels still owed to the current image
    assign rem        = fresh_reg ? total_pixels : remaining_reg;
    assign last_ch    = alpha_present ? CH_ALPHA : CH_RED;
    assign final_byte = !expect_reg && (chan_reg == last_ch);
    assign pix_count  = run_reg ? left_reg : CNT_W'(1);
    assign image_end  = {{(TOT_W-CNT_W){1'b0}}, pix_count} >= rem;

    // Pixel group handed to the back end
    assign cmd_push  = beat && final_byte;
    assign cmd.count = image_end ? rem[CNT_W-1:0] : pix_count;
    assign cmd.red   = alpha_present ? red_reg : pix_in.data_byte;
    assign cmd.green = green_reg;
    assign cmd.blue  = blue_reg;
    assign cmd.alpha = alpha_present ? pix_in.data_byte : OPAQUE;

    // Byte classification and next state
    always_comb
    begin
        expect_next    = expect_reg;
        run_next       = run_reg;
        left_next      = left_reg;
        chan_next      = chan_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        red_next       = red_reg;
        fresh_next     = fresh_reg;
        remaining_next = remaining_reg;
        if (rewind)
        begin
            expect_next = 1'b1;
            run_next    = 1'b0;
            left_next   = '0;
            chan_next   = CH_BLUE;
            fresh_next  = 1'b1;
        end
        else if (beat)
        begin
            if (expect_reg)
            begin
                run_next    = (pix_in.data_byte & RUN_BIT) != 8'd0;
                left_next   = (pix_in.data_byte & COUNT_MASK) + CNT_W'(1);
                chan_next   = CH_BLUE;
                expect_next = 1'b0;
            end
            else if (!final_byte)
            begin
                unique case (chan_reg)
                    CH_BLUE:  blue_next  = pix_in.data_byte;
                    CH_GREEN: green_next = pix_in.data_byte;
                    default:  red_next   = pix_in.data_byte;
                endcase
                chan_next = chan_t'(chan_reg + 2'd1);
            end
            else
            begin
                chan_next = CH_BLUE;
                if (!alpha_present)
                    red_next = pix_in.data_byte;
                if (run_reg)
                begin
                    left_next   = '0;
                    expect_next = 1'b1;
                end
                else
                begin
                    if (left_reg != '0)
                        left_next = left_reg - CNT_W'(1);
                    if (left_reg <= CNT_W'(1))
                        expect_next = 1'b1;
                end
                // Last pixel of the image: close the packet and restart the pixel count
                if (image_end)
                begin
                    fresh_next  = 1'b1;
                    expect_next = 1'b1;
                    run_next    = 1'b0;
                    left_next   = '0;
                end
                else
                begin
                    fresh_next     = 1'b0;
                    remaining_next = rem - {{(TOT_W-CNT_W){1'b0}}, pix_count};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg    <= 1'b1;
            run_reg       <= 1'b0;
            left_reg      <= '0;
            chan_reg      <= CH_BLUE;
            blue_reg      <= '0;
            green_reg     <= '0;
            red_reg       <= '0;
            fresh_reg     <= 1'b1;
            remaining_reg <= '0;
        end
        else
        begin
            expect_reg    <= expect_next;
            run_reg       <= run_next;
            left_reg      <= left_next;
            chan_reg      <= chan_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            red_reg       <= red_next;
            fresh_reg     <= fresh_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tga_rle_cmd_fifo.sv
// Short queue of pixel groups between the front and back ends.
`default_nettype none
module tga_rle_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tga_rle_pkg::cmd_t wdata,
    output logic              full,
    input  logic              pop,
    output tga_rle_pkg::cmd_t rdata,
    output logic              empty
);
    import tga_rle_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full  = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign rdata = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - (FIFO_AW+1)'(1);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tga_rle_back.sv
// Back end: splits pixel groups into row spans and tracks the raster position.
`default_nettype none
module tga_rle_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rewind,
    input  tga_rle_pkg::geom_t geom,
    input  tga_rle_pkg::cmd_t  head,
    input  logic               head_valid,
    output logic               pop,
    tga_rle_out_if.source      span_out
);
    import tga_rle_pkg::*;

    logic             busy_reg;
    logic [CNT_W-1:0] left_reg;
    logic [7:0]       red_reg, green_reg, blue_reg, alpha_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_reg;

    logic             out_valid_reg;
    logic [POS_W-1:0] out_row_reg, out_col_reg;
    logic [CNT_W-1:0] out_len_reg;
    logic [7:0]       out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic             out_last_reg, out_done_reg;

    logic             slot_free;
    logic             emit;
    logic [DIM_W-1:0] room;
    logic [CNT_W-1:0] len;
    logic [DIM_W-1:0] end_col;
    logic             row_end;
    logic             done;

    assign slot_free = !out_valid_reg || span_out.ready;
    assign pop       = !busy_reg && head_valid;
    assign emit      = busy_reg && slot_free;

    // Span length: rest of the group, cut at the row end
    assign room    = geom.width - {1'b0, col_reg};
    assign len     = ({{(DIM_W-CNT_W){1'b0}}, left_reg} < room) ? left_reg : room[CNT_W-1:0];
    assign end_col = {1'b0, col_reg} + {{(DIM_W-CNT_W){1'b0}}, len};
    assign row_end = end_col >= geom.width;
    assign done    = row_end && (row_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (rewind)
        begin
            row_reg <= geom.last_row;
            col_reg <= '0;
        end
        else
        begin
            // Output register handshake
            if (emit)
                out_valid_reg <= 1'b1;
            else if (span_out.ready)
                out_valid_reg <= 1'b0;

            // Take the next group from the queue
            if (pop)
            begin
                busy_reg <= 1'b1;
                left_reg <= head.count;
            end
            else if (emit)
            begin
                left_reg <= left_reg - len;
                if (left_reg == len)
                    busy_reg <= 1'b0;
                // Raster advance; row zero complete rewinds to the top row
                if (row_end)
                begin
                    col_reg <= '0;
                    if (done)
                        row_reg <= geom.last_row;
                    else
                        row_reg <= row_reg - POS_W'(1);
                end
                else
                begin
                    col_reg <= end_col[POS_W-1:0];
                end
            end
        end
    end

    // Group colour and span payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            red_reg   <= head.red;
            green_reg <= head.green;
            blue_reg  <= head.blue;
            alpha_reg <= head.alpha;
        end
        if (emit)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_len_reg   <= len;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_alpha_reg <= alpha_reg;
            out_last_reg  <= (left_reg == len) || done;
            out_done_reg  <= done;
        end
    end

    assign span_out.valid        = out_valid_reg;
    assign span_out.buffer_row   = out_row_reg;
    assign span_out.start_column = out_col_reg;
    assign span_out.span_length  = out_len_reg;
    assign span_out.red          = out_red_reg;
    assign span_out.green        = out_green_reg;
    assign span_out.blue         = out_blue_reg;
    assign span_out.alpha        = out_alpha_reg;
    assign span_out.last_span    = out_last_reg;
    assign span_out.image_done   = out_done_reg;

endmodule
`default_nettype wire

// File: rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: configuration and wiring.
//
//  channel   | dir | beat carries
//  ----------+-----+--------------------------------------------------------
//  cfg       | in  | index, data: register write (0 width, 1 height, 2 alpha)
//  pix_in    | in  | data_byte: packet byte or channel byte
//  span_out  | out | buffer_row, start_column, span_length, RGBA, flags
//
// The front end takes bytes while the queue has room and rewind is low; each
// pixel group goes through a four-entry queue to the span splitter, which
// loads a group when idle and issues its row spans in turn. A write to a
// known register holds pix_in off for one cycle while the pixel total and
// start row settle. Reset gives width 4, height 1, 24-bit mode. Either side
// may stall freely; the queue and output register decouple them.
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"
module tga_rle_pixel_decoder (
    input  logic           clk,
    input  logic           rst_n,
    tga_rle_cfg_if.sink    cfg,
    tga_rle_in_if.sink     pix_in,
    tga_rle_out_if.source  span_out
);
    import tga_rle_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             alpha_reg;
    logic             settle_reg;
    logic [TOT_W-1:0] total_reg;

    logic             cfg_beat;
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;
    logic [TOT_W-1:0] area;
    geom_t            geom;

    logic             cmd_push;
    cmd_t             cmd_in;
    cmd_t             cmd_head;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;

    logic             cfg_known;
    logic             pix_beat;
    logic             span_done;
    logic             span_fits;

    assign cfg.ready = 1'b1;
    assign cfg_beat  = cfg.valid && cfg.ready;

    // Geometry clamped to the supported range
    always_comb
    begin
        priority if (width_reg < DIM_W'(MIN_WIDTH))
            eff_width = DIM_W'(MIN_WIDTH);
        else if (width_reg > DIM_W'(MAX_DIM))
            eff_width = DIM_W'(MAX_DIM);
        else
            eff_width = width_reg;
        priority if (height_reg == '0)
            eff_height = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_DIM))
            eff_height = DIM_W'(MAX_DIM);
        else
            eff_height = height_reg;
    end

    assign geom.width    = eff_width;
    assign geom.last_row = POS_W'(eff_height - DIM_W'(1));

    // Pixels per image
    assign area = {{(TOT_W-DIM_W){1'b0}}, eff_width} * {{(TOT_W-DIM_W){1'b0}}, eff_height};

    // Configuration registers; a write to a known register rewinds the image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(4);
            height_reg <= DIM_W'(1);
            alpha_reg  <= 1'b0;
            settle_reg <= 1'b0;
            total_reg  <= TOT_W'(4);
        end
        else
        begin
            settle_reg <= 1'b0;
            if (cfg_beat)
            begin
                if (cfg.index == REG_IMAGE_WIDTH)
                begin
                    width_reg  <= cfg.data;
                    settle_reg <= 1'b1;
                end
                else if (cfg.index == REG_IMAGE_HEIGHT)
                begin
                    height_reg <= cfg.data;
                    settle_reg <= 1'b1;
                end
                else if (cfg.index == REG_ALPHA_PRESENT)
                begin
                    alpha_reg  <= cfg.data[0];
                    settle_reg <= 1'b1;
                end
            end
            // Pixels per image, registered after the multiplier
            total_reg <= area;
        end
    end

    tga_rle_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .rewind        (settle_reg),
        .alpha_present (alpha_reg),
        .total_pixels  (total_reg),
        .pix_in        (pix_in),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in),
        .cmd_full      (cmd_full)
    );

    tga_rle_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_head),
        .empty (cmd_empty)
    );

    tga_rle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rewind     (settle_reg),
        .geom       (geom),
        .head       (cmd_head),
        .head_valid (!cmd_empty),
        .pop        (cmd_pop),
        .span_out   (span_out)
    );

    // Terms for the checks
    assign cfg_known = cfg_beat && (cfg.index == REG_IMAGE_WIDTH ||
                                    cfg.index == REG_IMAGE_HEIGHT ||
                                    cfg.index == REG_ALPHA_PRESENT);
    assign pix_beat  = pix_in.valid && pix_in.ready;
    assign span_done = span_out.valid && span_out.image_done;
    assign span_fits = ({1'b0, span_out.start_column} +
                        {{(DIM_W-CNT_W){1'b0}}, span_out.span_length}) <= geom.width;

    // Checks
    `TGA_ASSERT_IMP(a_done_is_last, clk, rst_n, span_done, span_out.last_span, "done not last")
    `TGA_ASSERT_IMP(a_span_in_row, clk, rst_n, span_out.valid, span_fits, "span past row end")
    `TGA_ASSERT_NEXT(a_cfg_holds_input, clk, rst_n, cfg_known, !pix_beat, "byte taken in settle")

endmodule
`default_nettype wire

// File: verif/tga_rle_pixel_decoder_tb.sv
// Self-checking testbench for the TGA run-length pixel decoder.
`timescale 1ns / 100ps
module tga_rle_pixel_decoder_tb;
    import tga_rle_pkg::*;

    localparam int          RUN_LIMIT_NS  = 2_000_000;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          RANDOM_BYTES  = 140;
    localparam int          MAX_SPANS     = 34;
    localparam int          PRINT_CAP     = 40;
    // Index outside the register map: the write must leave the decoder alone
    localparam logic [7:0]  REG_UNUSED    = 8'd3;

    // One row span as seen on the output channel
    typedef struct {
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  len;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        last;
        logic        done;
    } span_t;

    typedef enum bit {ROW_BYTE, ROW_REG} row_kind_t;

    // Directed stimulus row: a coded byte or a register write
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  idx;
        logic [12:0] val;
        bit          typed;
        span_t       want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    tga_rle_cfg_if cfg_if();
    tga_rle_in_if  pix_if();
    tga_rle_out_if span_if();

    tga_rle_pixel_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_if),
        .pix_in   (pix_if),
        .span_out (span_if)
    );

    // Decoder state as the predictor sees it
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic        cfg_alpha;
    bit          hdr_wait;
    bit          run_mode;
    int          px_left;
    chan_t       chan;
    logic [7:0]  hold_b;
    logic [7:0]  hold_g;
    logic [7:0]  hold_r;
    int          row_pos;
    int          col_pos;

    span_t       fresh_spans[$];
    span_t       pending_spans[$];
    plan_row_t   plan[$];
    span_t       no_span;

    int fault_count;
    int bytes_sent;
    int reg_writes;
    int spans_seen;
    int images_seen;
    bit source_calm;
    bit sink_calm;
    int sink_hold;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d spans outstanding", pending_spans.size());
        $display("status: fail");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        fault_count++;
        if (fault_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w < MIN_WIDTH)
            w = MIN_WIDTH;
        if (w > MAX_DIM)
            w = MAX_DIM;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = cfg_height;
        if (h < 1)
            h = 1;
        if (h > MAX_DIM)
            h = MAX_DIM;
        return h;
    endfunction

    // Back to the top row, waiting for a packet byte
    task automatic rewind_pos();
        hdr_wait = 1'b1;
        run_mode = 1'b0;
        px_left  = 0;
        chan     = CH_BLUE;
        row_pos  = eff_height() - 1;
        col_pos  = 0;
    endtask

    task automatic apply_reg(input logic [7:0] idx, input logic [12:0] val);
        bit known;
        known = 1'b1;
        case (idx)
            REG_IMAGE_WIDTH:   cfg_width  = val;
            REG_IMAGE_HEIGHT:  cfg_height = val;
            REG_ALPHA_PRESENT: cfg_alpha  = val[0];
            default:           known      = 1'b0;
        endcase
        if (known)
            rewind_pos();
    endtask

    // Split count pixels of one colour into row spans; stop at image end
    task automatic paint(input int count, input logic [7:0] r, input logic [7:0] g,
                         input logic [7:0] bl, input logic [7:0] a);
        int    w;
        int    room;
        int    len;
        int    n;
        bit    done;
        span_t s;
        w = eff_width();
        n = 0;
        while (count > 0 && n < MAX_SPANS)
        begin
            room   = w - col_pos;
            len    = (count < room) ? count : room;
            s.row  = row_pos[11:0];
            s.col  = col_pos[11:0];
            s.len  = len[7:0];
            s.r    = r;
            s.g    = g;
            s.b    = bl;
            s.a    = a;
            s.last = 1'b0;
            n++;
            count   -= len;
            col_pos += len;
            done     = 1'b0;
            if (col_pos >= w)
            begin
                col_pos = 0;
                if (row_pos > 0)
                    row_pos--;
                else
                    done = 1'b1;
            end
            s.done = done;
            fresh_spans.push_back(s);
            if (done)
            begin
                rewind_pos();
                count = 0;
            end
        end
    endtask

    // Spans caused by one coded byte, left in fresh_spans
    task automatic decode_byte(input logic [7:0] b);
        chan_t      last_ch;
        logic [7:0] r;
        logic [7:0] a;
        int         cnt;
        span_t      s;
        fresh_spans.delete();
        last_ch = cfg_alpha ? CH_ALPHA : CH_RED;
        if (hdr_wait)
        begin
            run_mode = ((b & RUN_BIT) != 8'd0);
            px_left  = int'(b & COUNT_MASK) + 1;
            chan     = CH_BLUE;
            hdr_wait = 1'b0;
        end
        else if (chan < last_ch)
        begin
            case (chan)
                CH_BLUE:  hold_b = b;
                CH_GREEN: hold_g = b;
                default:  hold_r = b;
            endcase
            chan = chan_t'(chan + 1);
        end
        else
        begin
            // closing byte of a pixel
            if (cfg_alpha)
            begin
                r = hold_r;
                a = b;
            end
            else
            begin
                hold_r = b;
                r      = b;
                a      = OPAQUE;
            end
            chan = CH_BLUE;
            if (run_mode)
            begin
                cnt      = px_left;
                px_left  = 0;
                hdr_wait = 1'b1;
                paint(cnt, r, hold_g, hold_b, a);
            end
            else
            begin
                if (px_left > 0)
                    px_left--;
                if (px_left == 0)
                    hdr_wait = 1'b1;
                paint(1, r, hold_g, hold_b, a);
            end
            if (fresh_spans.size() > 0)
            begin
                s      = fresh_spans.pop_back();
                s.last = 1'b1;
                fresh_spans.push_back(s);
            end
        end
    endtask

    // Directed table builders
    function automatic void add_byte(input logic [7:0] b);
        plan_row_t p;
        p.kind  = ROW_BYTE;
        p.idx   = 8'd0;
        p.val   = {5'd0, b};
        p.typed = 1'b0;
        p.want  = no_span;
        plan.push_back(p);
    endfunction

    function automatic void add_reg(input logic [7:0] idx, input logic [12:0] val);
        plan_row_t p;
        p.kind  = ROW_REG;
        p.idx   = idx;
        p.val   = val;
        p.typed = 1'b0;
        p.want  = no_span;
        plan.push_back(p);
    endfunction

    function automatic void add_typed(input logic [7:0] b, input logic [11:0] row,
                                      input logic [11:0] col, input logic [7:0] len,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] bl, input logic [7:0] a,
                                      input logic last, input logic done);
        plan_row_t p;
        p.kind  = ROW_BYTE;
        p.idx   = 8'd0;
        p.val   = {5'd0, b};
        p.typed = 1'b1;
        p.want  = '{row, col, len, r, g, bl, a, last, done};
        plan.push_back(p);
    endfunction

    // One coded byte; valid is left high unless a gap follows
    task automatic send_byte(input logic [7:0] b, input bit typed, input span_t want);
        int pause;
        int k;
        pix_if.valid     <= 1'b1;
        pix_if.data_byte <= b;
        do
            @(posedge clk);
        while (pix_if.ready !== 1'b1);
        decode_byte(b);
        bytes_sent++;
        if (typed)
        begin
            if (fresh_spans.size() != 1)
                log_mismatch($sformatf("directed byte %02h: predictor gives %0d spans",
                                       b, fresh_spans.size()));
            pending_spans.push_back(want);
        end
        else
        begin
            for (k = 0; k < fresh_spans.size(); k++)
                pending_spans.push_back(fresh_spans[k]);
        end
        @(negedge clk);
        pause = source_calm ? 0 : pick_pause();
        if (pause > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [12:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        apply_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, let every expected span out, then let the pipe go quiet
    task automatic settle_idle();
        pix_if.valid <= 1'b0;
        while (pending_spans.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [12:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 13'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(4, 12));
        endcase
    endfunction

    function automatic logic [12:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'($urandom_range(4096, 8191));
            default: return 13'($urandom_range(1, 4));
        endcase
    endfunction

    // Sink side: random back-pressure
    initial
    begin
        span_if.ready = 1'b0;
        sink_hold     = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                span_if.ready <= 1'b0;
            end
            else
            begin
                span_if.ready <= 1'b1;
                sink_hold = sink_calm ? 0 : pick_pause();
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            log_mismatch($sformatf("span %0d %s = %0h, expected %0h",
                                   spans_seen, name, got, want));
    endtask

    // Output monitor: every accepted beat against the oldest expectation
    initial
    begin
        span_t got;
        span_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && span_if.valid === 1'b1 && span_if.ready === 1'b1)
            begin
                got = '{span_if.buffer_row, span_if.start_column, span_if.span_length,
                        span_if.red, span_if.green, span_if.blue, span_if.alpha,
                        span_if.last_span, span_if.image_done};
                if (pending_spans.size() == 0)
                    log_mismatch($sformatf("unexpected span row %0d col %0d len %0d",
                                           got.row, got.col, got.len));
                else
                begin
                    want = pending_spans.pop_front();
                    check_field("buffer_row",   16'(got.row),  16'(want.row));
                    check_field("start_column", 16'(got.col),  16'(want.col));
                    check_field("span_length",  16'(got.len),  16'(want.len));
                    check_field("red",          16'(got.r),    16'(want.r));
                    check_field("green",        16'(got.g),    16'(want.g));
                    check_field("blue",         16'(got.b),    16'(want.b));
                    check_field("alpha",        16'(got.a),    16'(want.a));
                    check_field("last_span",    16'(got.last), 16'(want.last));
                    check_field("image_done",   16'(got.done), 16'(want.done));
                end
                spans_seen++;
                if (got.done === 1'b1)
                    images_seen++;
            end
        end
    end

    // Stimulus
    initial
    begin
        int         i;
        int         random_bytes;
        int         budget;
        int         sent;
        int         cnt;
        int         nbytes;
        int         k;
        bit         is_run;
        logic [7:0] hdr;

        pix_if.valid     = 1'b0;
        pix_if.data_byte = 8'd0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = 8'd0;
        cfg_if.data      = 13'd0;
        rst_n            = 1'b0;
        fault_count      = 0;
        bytes_sent       = 0;
        reg_writes       = 0;
        spans_seen       = 0;
        images_seen      = 0;
        source_calm      = 1'b0;
        sink_calm        = 1'b0;
        no_span          = '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};

        // reset values of the decoder
        cfg_width  = 13'd4;
        cfg_height = 13'd1;
        cfg_alpha  = 1'b0;
        hold_b     = 8'd0;
        hold_g     = 8'd0;
        hold_r     = 8'd0;
        rewind_pos();

        // Directed: 4x1 24-bit image after reset, one raw pixel then a run to the end
        add_byte(8'd0);
        add_byte(8'h10);
        add_byte(8'h20);
        add_typed(8'h30, 12'd0, 12'd0, 8'd1, 8'h30, 8'h20, 8'h10, OPAQUE, 1'b1, 1'b0);
        add_byte(RUN_BIT | 8'd2);
        add_byte(8'h00);
        add_byte(8'h00);
        add_typed(8'h00, 12'd0, 12'd1, 8'd3, 8'h00, 8'h00, 8'h00, OPAQUE, 1'b1, 1'b1);
        // width below the minimum, two rows, 32-bit; longest run cut by image end
        add_reg(REG_IMAGE_WIDTH, 13'd0);
        add_reg(REG_IMAGE_HEIGHT, 13'd2);
        add_reg(REG_ALPHA_PRESENT, 13'd1);
        add_byte(RUN_BIT | COUNT_MASK);
        add_byte(8'hff);
        add_byte(8'hff);
        add_byte(8'hff);
        add_byte(8'hff);
        // longest raw packet, one pixel, then a partial pixel
        add_byte(COUNT_MASK);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'h03);
        add_typed(8'h04, 12'd1, 12'd0, 8'd1, 8'h03, 8'h02, 8'h01, 8'h04, 1'b1, 1'b0);
        add_byte(8'h55);
        // oversized geometry clamps; write mid-packet rewinds
        add_reg(REG_IMAGE_WIDTH, 13'd8191);
        add_reg(REG_IMAGE_HEIGHT, 13'd8191);
        add_reg(REG_ALPHA_PRESENT, 13'd0);
        add_reg(REG_UNUSED, 13'd0);
        add_byte(RUN_BIT);
        add_byte(8'haa);
        add_byte(8'h55);
        add_typed(8'haa, 12'd4095, 12'd0, 8'd1, 8'haa, 8'h55, 8'haa, OPAQUE, 1'b1, 1'b0);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_REG)
            begin
                settle_idle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_byte(plan[i].val[7:0], plan[i].typed, plan[i].want);
        end

        // Random: one geometry per burst of packets
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            settle_idle();
            source_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            write_reg(REG_IMAGE_WIDTH, pick_width());
            write_reg(REG_IMAGE_HEIGHT, pick_height());
            write_reg(REG_ALPHA_PRESENT, 13'($urandom));
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_UNUSED, 13'($urandom));
            budget = $urandom_range(12, 40);
            sent   = 0;
            while (sent < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise bytes
                    repeat ($urandom_range(1, 4))
                    begin
                        send_byte(8'($urandom), 1'b0, no_span);
                        sent++;
                    end
                end
                else
                begin
                    is_run = $urandom_range(0, 1);
                    if (is_run)
                        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 7);
                    else
                        cnt = ($urandom_range(0, 24) == 0) ? 127 : $urandom_range(0, 7);
                    hdr = (is_run ? RUN_BIT : 8'd0) | (8'(cnt) & COUNT_MASK);
                    send_byte(hdr, 1'b0, no_span);
                    sent++;
                    nbytes = (is_run ? 1 : cnt + 1) * (cfg_alpha ? 4 : 3);
                    // occasionally a cut-off packet
                    if ($urandom_range(0, 15) == 0)
                        nbytes = $urandom_range(0, nbytes - 1);
                    for (k = 0; k < nbytes && sent < budget + 8; k++)
                    begin
                        send_byte(8'($urandom), 1'b0, no_span);
                        sent++;
                    end
                end
            end
            random_bytes += sent;
        end

        // Drain
        settle_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("covered %0d coded bytes and %0d register writes, with random stalls",
                 bytes_sent, reg_writes);
        $display("checked %0d spans over %0d completed images, %0d mismatches",
                 spans_seen, images_seen, fault_count);
        if (fault_count == 0 && pending_spans.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tga_rle_pkg.sv
rtl/core/tga_rle_if.sv
rtl/core/tga_rle_front.sv
rtl/core/tga_rle_cmd_fifo.sv
rtl/core/tga_rle_back.sv
rtl/core/tga_rle_pixel_decoder.sv
verif/tga_rle_pixel_decoder_tb.sv
